// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion held off while reset is high
`define CHK_ASSERT(lbl, c_clk, c_rst, prop) \
  lbl: assert property (@(posedge c_clk) disable iff (c_rst) prop) \
    else $error("assertion failed");

// assertion that is checked through reset as well
`define CHK_ASSERT_ALWAYS(lbl, c_clk, prop) \
  lbl: assert property (@(posedge c_clk) prop) else $error("assertion failed");

`endif

// ----- hw/rtl/mbrs_pkg.sv -----
// ---------------------------------------------------------------------------
// mbrs_pkg
// Types, codes and helper tables of the register slave.
// ---------------------------------------------------------------------------
package mbrs_pkg;

  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int MAX_READ_REGS_DEF = 16;

  localparam logic [7:0]  FN_RD_HOLD   = 8'h03;
  localparam logic [7:0]  FN_RD_INPUT  = 8'h04;
  localparam logic [7:0]  FN_WR_SINGLE = 8'h06;
  localparam logic [7:0]  FN_WR_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic        CMD_FRAME    = 1'b0;
  localparam logic        CMD_APP      = 1'b1;

  typedef logic [7:0] slot_lut_t [256];

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] fn;
    logic [7:0] h3;
    logic [7:0] h4;
    logic [7:0] h5;
    logic [7:0] h6;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_WAIT,
    B_CRC,
    B_EMIT
  } back_state_t;

  // address byte to table slot, wrapping at depth
  function automatic slot_lut_t make_slot_lut(input int depth);
    slot_lut_t lut;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      lut[i] = 8'(r);
      if (r == depth - 1) r = 0;
      else r = r + 1;
    end
    return lut;
  endfunction

endpackage

// ----- hw/rtl/mbrs_ram.sv -----
// ---------------------------------------------------------------------------
// mbrs_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module mbrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mbrs_front.sv -----
// ---------------------------------------------------------------------------
// mbrs_front
// Takes request and application words, captures the header, performs table
// writes and queues one response job per valid frame. After reset it zeroes
// both tables, one entry per cycle, with the input held off.
// ---------------------------------------------------------------------------
module mbrs_front #(
  parameter int TABLE_DEPTH = mbrs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  output logic                           hold_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] hold_waddr,
  output logic [15:0]                    hold_wdata,
  output logic                           inp_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] inp_waddr,
  output logic [15:0]                    inp_wdata,
  output mbrs_pkg::job_t                 job,
  output logic                           job_valid,
  input  logic                           job_done
);
  import mbrs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam slot_lut_t SLOT_LUT = make_slot_lut(TABLE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);

  logic [7:0]    pos;
  logic [7:0]    hdr [7];
  logic [7:0]    hdr_next [7];
  logic [7:0]    pend;
  logic [7:0]    cursor;
  logic [7:0]    b;
  logic [7:0]    word_idx;
  logic          frame_acc;
  logic          multi_wr;
  logic          single_wr;
  logic          push;
  logic          data_pos;
  logic          clr_busy;
  logic [AW-1:0] clr_idx;

  assign s_tready  = !job_valid && !clr_busy;
  assign b         = s_tdata[7:0];
  assign frame_acc = s_tvalid && s_tready && (s_tuser == CMD_FRAME);
  assign data_pos  = (pos >= 8'd8) && (pos != 8'd255) && (hdr[2] == FN_WR_MULTI);
  assign word_idx  = (pos - 8'd9) >> 1;

  always_comb begin
    hdr_next = hdr;
    if (frame_acc && pos < 8'd7) hdr_next[pos[2:0]] = b;
  end

  assign multi_wr  = frame_acc && data_pos && pos[0] && (word_idx < hdr[6]);
  assign single_wr = frame_acc && s_tlast && (hdr_next[2] == FN_WR_SINGLE);
  assign push      = frame_acc && s_tlast &&
                     ((hdr_next[2] == FN_RD_HOLD) || (hdr_next[2] == FN_RD_INPUT) ||
                      (hdr_next[2] == FN_WR_SINGLE) || (hdr_next[2] == FN_WR_MULTI));

  // clearing pass owns both write ports while it runs
  assign hold_we    = clr_busy || (s_tvalid && s_tready && (s_tuser == CMD_APP));
  assign hold_waddr = clr_busy ? clr_idx : SLOT_LUT[s_tdata[15:8]][AW-1:0];
  assign hold_wdata = clr_busy ? 16'h0000 : s_tdata[31:16];

  assign inp_we    = clr_busy || multi_wr || single_wr;
  assign inp_waddr = clr_busy  ? clr_idx :
                     single_wr ? SLOT_LUT[hdr_next[4]][AW-1:0] : SLOT_LUT[cursor][AW-1:0];
  assign inp_wdata = clr_busy  ? 16'h0000 :
                     single_wr ? {hdr_next[5], hdr_next[6]} : {pend, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      pend      <= '0;
      cursor    <= '0;
      job_valid <= 1'b0;
      clr_busy  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CLR_LAST) clr_busy <= 1'b0;
      end
      if (frame_acc) begin
        if (s_tlast) pos <= '0;
        else if (pos != 8'd255) pos <= pos + 8'd1;
        if (pos == 8'd4) cursor <= b;
        if (data_pos && !pos[0]) pend <= b;
      end
      if (multi_wr) cursor <= cursor + 8'd1;
      if (push) job_valid <= 1'b1;
      else if (job_done) job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc) hdr <= hdr_next;
    if (push) begin
      job.addr <= hdr_next[1];
      job.fn   <= hdr_next[2];
      job.h3   <= hdr_next[3];
      job.h4   <= hdr_next[4];
      job.h5   <= hdr_next[5];
      job.h6   <= hdr_next[6];
    end
  end

endmodule

// ----- hw/rtl/mbrs_back.sv -----
// ---------------------------------------------------------------------------
// mbrs_back
// Builds the response of a queued job byte by byte, reads table words,
// runs the CRC one bit per cycle and drives the output register.
// ---------------------------------------------------------------------------
module mbrs_back #(
  parameter int TABLE_DEPTH   = mbrs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_READ_REGS = mbrs_pkg::MAX_READ_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mbrs_pkg::job_t                 job,
  input  logic                           job_valid,
  output logic                           job_done,
  output logic                           rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [15:0]                    hold_rdata,
  input  logic [15:0]                    inp_rdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast
);
  import mbrs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam slot_lut_t SLOT_LUT = make_slot_lut(TABLE_DEPTH);
  localparam logic [7:0] MAX_Q = 8'(MAX_READ_REGS);

  back_state_t state, state_next;
  logic [7:0]  k;
  logic [2:0]  bit_cnt;
  logic [15:0] crc;
  logic [7:0]  cur;
  logic [15:0] word;
  logic [7:0]  waddr;
  logic        is_read;
  logic [7:0]  q;
  logic [7:0]  nd;
  logic        need_rd;
  logic [7:0]  body_byte;
  logic        out_free;
  logic        last_byte;
  logic [15:0] word_now;

  assign is_read   = (job.fn == FN_RD_HOLD) || (job.fn == FN_RD_INPUT);
  assign q         = (job.h6 > MAX_Q) ? MAX_Q : job.h6;
  assign nd        = is_read ? (8'd3 + {q[6:0], 1'b0}) : 8'd6;
  assign need_rd   = is_read && (k >= 8'd3) && k[0];
  assign out_free  = !m_tvalid || m_tready;
  assign last_byte = (k == nd + 8'd1);
  assign rd_addr   = SLOT_LUT[waddr][AW-1:0];
  assign word_now  = (job.fn == FN_RD_HOLD) ? hold_rdata : inp_rdata;

  always_comb begin
    body_byte = job.addr;
    priority if (k == 8'd0) body_byte = job.addr;
    else if (k == 8'd1) body_byte = job.fn;
    else if (is_read && k == 8'd2) body_byte = {q[6:0], 1'b0};
    else if (is_read) body_byte = word[7:0];
    else if (k == 8'd2) body_byte = job.h3;
    else if (k == 8'd3) body_byte = job.h4;
    else if (k == 8'd4) body_byte = job.h5;
    else body_byte = job.h6;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = B_PREP;
      B_PREP: begin
        if (k < nd) state_next = need_rd ? B_WAIT : B_CRC;
        else state_next = B_EMIT;
      end
      B_WAIT: state_next = B_CRC;
      B_CRC:  if (bit_cnt == 3'd7) state_next = B_EMIT;
      B_EMIT: if (out_free) state_next = last_byte ? B_IDLE : B_PREP;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    job_done = 1'b0;
    unique case (state)
      B_PREP:  rd_en = (k < nd) && need_rd;
      B_EMIT:  job_done = out_free && last_byte;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tready) m_tvalid <= 1'b0;
      if (state == B_EMIT && out_free) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        k     <= '0;
        crc   <= CRC_INIT;
        waddr <= job.h4;
      end
      B_PREP: begin
        bit_cnt <= '0;
        if (k < nd) begin
          if (need_rd) begin
            waddr <= waddr + 8'd1;
          end else begin
            cur <= body_byte;
            crc <= crc ^ {8'h00, body_byte};
          end
        end else if (k == nd) begin
          cur <= crc[7:0];
        end else begin
          cur <= crc[15:8];
        end
      end
      B_WAIT: begin
        word <= word_now;
        cur  <= word_now[15:8];
        crc  <= crc ^ {8'h00, word_now[15:8]};
      end
      B_CRC: begin
        bit_cnt <= bit_cnt + 3'd1;
        crc     <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      B_EMIT: begin
        if (out_free) begin
          m_tdata <= cur;
          m_tlast <= last_byte;
          k       <= k + 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/modbus_register_slave_unit.sv -----
// Each response byte passes prep, the CRC step (CRC runs one bit per cycle) and emit; the high byte of a
// register first waits on the table read, and the two CRC bytes go from prep straight to emit.
// The next request word waits until the whole response has gone out.
// Reset: synchronous; clears control state, then a clearing pass zeroes every entry of
// both tables while the input is held off.
// ---------------------------------------------------------------------------
// modbus_register_slave_unit
// Register server: front captures frames, back streams the response.
// ---------------------------------------------------------------------------
module modbus_register_slave_unit #(
  parameter int TABLE_DEPTH   = mbrs_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_READ_REGS = mbrs_pkg::MAX_READ_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // frame_byte[7:0], app_index[15:8], app_word[31:16]
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // resp_byte[7:0]
  output logic        m_tlast    // resp_last
);
  import mbrs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                   hold_we, inp_we, rd_en, job_valid, job_done;
  logic [AW-1:0]          hold_waddr, inp_waddr, rd_addr;
  logic [15:0]            hold_wdata, inp_wdata, hold_rdata, inp_rdata;
  job_t                   job;

  mbrs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .hold_we, .hold_waddr, .hold_wdata, .inp_we, .inp_waddr, .inp_wdata,
    .job, .job_valid, .job_done
  );

  mbrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_hold_ram (
    .clk, .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(hold_rdata)
  );

  mbrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_inp_ram (
    .clk, .we(inp_we), .waddr(inp_waddr), .wdata(inp_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(inp_rdata)
  );

  mbrs_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_READ_REGS(MAX_READ_REGS)) u_back (
    .clk, .rst, .job, .job_valid, .job_done, .rd_en, .rd_addr,
    .hold_rdata, .inp_rdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

// ----- hw/rtl/mbrs_checker.sv -----
// ---------------------------------------------------------------------------
// mbrs_checker
// Port-level checks of the register slave, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mbrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // stalled response word holds
  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> $stable({m_tvalid, m_tdata, m_tlast}))

  // no new request taken mid-response
  `CHK_ASSERT(a_busy_block, clk, rst, m_tvalid && !m_tlast |-> !s_tready)

  // reset leaves the output empty and holds the input off for the clearing pass
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !s_tready && !m_tvalid)

endmodule

bind modbus_register_slave_unit mbrs_checker u_chk (.*);
